// ----- src/imde_pkg.sv -----
// shared types and constants of the integer matrix determinant engine
`default_nettype none

package imde_pkg;

  // operation codes carried in the func field
  localparam logic [2:0] FUNC_WRITE     = 3'd0;
  localparam logic [2:0] FUNC_TRANSPOSE = 3'd1;
  localparam logic [2:0] FUNC_SWAP      = 3'd2;
  localparam logic [2:0] FUNC_ADD       = 3'd3;
  localparam logic [2:0] FUNC_FACTOR    = 3'd4;
  localparam logic [2:0] FUNC_EVAL      = 3'd5;

  // controller state codes, also sent to the datapath as the step to run
  localparam int ST_W = 5;
  localparam logic [ST_W-1:0] S_IDLE     = 5'd0;
  localparam logic [ST_W-1:0] S_DISPATCH = 5'd1;
  localparam logic [ST_W-1:0] S_WRITE    = 5'd2;
  localparam logic [ST_W-1:0] S_RD       = 5'd3;
  localparam logic [ST_W-1:0] S_TR_W0    = 5'd4;
  localparam logic [ST_W-1:0] S_TR_W1    = 5'd5;
  localparam logic [ST_W-1:0] S_SW_W0    = 5'd6;
  localparam logic [ST_W-1:0] S_SW_W1    = 5'd7;
  localparam logic [ST_W-1:0] S_AD_WR    = 5'd8;
  localparam logic [ST_W-1:0] S_DV_LOAD  = 5'd9;
  localparam logic [ST_W-1:0] S_DV_STEP  = 5'd10;
  localparam logic [ST_W-1:0] S_FO_WR    = 5'd11;
  localparam logic [ST_W-1:0] S_EV_INIT  = 5'd12;
  localparam logic [ST_W-1:0] S_EV_SCAN  = 5'd13;
  localparam logic [ST_W-1:0] S_EV_M0    = 5'd14;
  localparam logic [ST_W-1:0] S_EV_M1    = 5'd15;
  localparam logic [ST_W-1:0] S_EV_ACC   = 5'd16;
  localparam logic [ST_W-1:0] S_EV_STORE = 5'd17;
  localparam logic [ST_W-1:0] S_SC0      = 5'd18;
  localparam logic [ST_W-1:0] S_SC1      = 5'd19;
  localparam logic [ST_W-1:0] S_SC2      = 5'd20;
  localparam logic [ST_W-1:0] S_FIN      = 5'd21;
  localparam logic [ST_W-1:0] S_OUT      = 5'd22;

  // input transaction
  typedef struct packed {
    logic [2:0]         func;
    logic [2:0]         index_a;
    logic [2:0]         index_b;
    logic               on_rows;
    logic signed [7:0]  factor;
    logic signed [31:0] element_value;
  } imde_item_t;

  // result transaction
  typedef struct packed {
    logic signed [63:0] det_value;
    logic signed [63:0] scaled_value;
    logic signed [31:0] coeff_out;
    logic               bad_op;
  } imde_result_t;

  // controller to datapath
  typedef struct packed {
    logic [ST_W-1:0] op;
    logic            capture;
  } imde_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [2:0] func;
    logic       bad;
    logic       skip;
    logic       t_last;
    logic       pair_last;
    logic       bit_set;
    logic       c_zero;
    logic       mask_full;
    logic       div_last;
  } imde_sts_t;

endpackage

`default_nettype wire

// ----- src/imde_ctrl.sv -----
// sequencing state machine of the determinant engine
`default_nettype none

module imde_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  input  wire imde_pkg::imde_sts_t sts,
  output imde_pkg::imde_cmd_t      cmd,
  output logic                     busy,
  output logic                     done
);

  logic [imde_pkg::ST_W-1:0] state;
  logic [imde_pkg::ST_W-1:0] state_next;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      imde_pkg::S_IDLE: begin
        if (start) state_next = imde_pkg::S_DISPATCH;
      end
      imde_pkg::S_DISPATCH: begin
        if (sts.bad) begin
          state_next = imde_pkg::S_FIN;
        end else begin
          case (sts.func)
            imde_pkg::FUNC_WRITE:     state_next = imde_pkg::S_WRITE;
            imde_pkg::FUNC_TRANSPOSE,
            imde_pkg::FUNC_SWAP:      state_next = sts.skip ? imde_pkg::S_FIN : imde_pkg::S_RD;
            imde_pkg::FUNC_ADD,
            imde_pkg::FUNC_FACTOR:    state_next = imde_pkg::S_RD;
            imde_pkg::FUNC_EVAL:      state_next = imde_pkg::S_EV_INIT;
            default:                  state_next = imde_pkg::S_FIN;
          endcase
        end
      end
      imde_pkg::S_WRITE: state_next = imde_pkg::S_FIN;
      imde_pkg::S_RD: begin
        case (sts.func)
          imde_pkg::FUNC_TRANSPOSE: state_next = imde_pkg::S_TR_W0;
          imde_pkg::FUNC_SWAP:      state_next = imde_pkg::S_SW_W0;
          imde_pkg::FUNC_ADD:       state_next = imde_pkg::S_AD_WR;
          default:                  state_next = imde_pkg::S_DV_LOAD;
        endcase
      end
      imde_pkg::S_TR_W0: state_next = imde_pkg::S_TR_W1;
      imde_pkg::S_TR_W1: state_next = sts.pair_last ? imde_pkg::S_FIN : imde_pkg::S_RD;
      imde_pkg::S_SW_W0: state_next = imde_pkg::S_SW_W1;
      imde_pkg::S_SW_W1: state_next = sts.t_last ? imde_pkg::S_FIN : imde_pkg::S_RD;
      imde_pkg::S_AD_WR: state_next = sts.t_last ? imde_pkg::S_FIN : imde_pkg::S_RD;
      imde_pkg::S_DV_LOAD: state_next = imde_pkg::S_DV_STEP;
      imde_pkg::S_DV_STEP: begin
        if (sts.div_last) state_next = imde_pkg::S_FO_WR;
      end
      imde_pkg::S_FO_WR: state_next = sts.t_last ? imde_pkg::S_FIN : imde_pkg::S_RD;
      imde_pkg::S_EV_INIT: state_next = imde_pkg::S_EV_SCAN;
      imde_pkg::S_EV_SCAN: begin
        if (sts.bit_set)     state_next = imde_pkg::S_EV_M0;
        else if (sts.c_zero) state_next = imde_pkg::S_EV_STORE;
      end
      imde_pkg::S_EV_M0:  state_next = imde_pkg::S_EV_M1;
      imde_pkg::S_EV_M1:  state_next = imde_pkg::S_EV_ACC;
      imde_pkg::S_EV_ACC: state_next = sts.c_zero ? imde_pkg::S_EV_STORE : imde_pkg::S_EV_SCAN;
      imde_pkg::S_EV_STORE: state_next = sts.mask_full ? imde_pkg::S_SC0 : imde_pkg::S_EV_SCAN;
      imde_pkg::S_SC0: state_next = imde_pkg::S_SC1;
      imde_pkg::S_SC1: state_next = imde_pkg::S_SC2;
      imde_pkg::S_SC2: state_next = imde_pkg::S_FIN;
      imde_pkg::S_FIN: state_next = imde_pkg::S_OUT;
      imde_pkg::S_OUT: state_next = imde_pkg::S_IDLE;
      default:         state_next = imde_pkg::S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= imde_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // commands and handshake
  assign cmd.op      = state;
  assign cmd.capture = (state == imde_pkg::S_IDLE) && start;
  assign busy        = (state != imde_pkg::S_IDLE);
  assign done        = (state == imde_pkg::S_OUT);

endmodule

`default_nettype wire

// ----- src/imde_dp.sv -----
// matrix store, minor store, shared multiplier and divider of the engine
`default_nettype none

module imde_dp #(
  parameter int MAX_ORDER  = 8,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_we,
  input  wire logic [3:0]           cfg_data,
  input  wire imde_pkg::imde_item_t item,
  input  wire imde_pkg::imde_cmd_t  cmd,
  output imde_pkg::imde_sts_t       sts,
  output imde_pkg::imde_result_t    result
);

  localparam int IW = $clog2(MAX_ORDER);
  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int MD = MAX_ORDER * MAX_ORDER;
  localparam int AW = $clog2(MD);
  localparam int MS = 1 << MAX_ORDER;
  localparam int CW = $clog2(ELEM_WIDTH);

  // configuration and captured transaction
  logic [3:0]         order;
  logic [NW-1:0]      n;
  logic [2:0]         func;
  logic [2:0]         ia;
  logic [2:0]         ib;
  logic               rows;
  logic signed [7:0]  k;
  logic signed [31:0] ev;

  // loop counters and evaluation state
  logic [IW-1:0]        t;
  logic [IW-1:0]        u;
  logic [IW-1:0]        c;
  logic [MAX_ORDER-1:0] mask;
  logic                 above;
  logic [63:0]          acc;
  logic [63:0]          p0;
  logic [31:0]          p1;
  logic [63:0]          det;
  logic [63:0]          scaled;
  logic signed [31:0]   coefficient;

  // stores and their read registers
  logic signed [ELEM_WIDTH-1:0] mem [MD];
  logic signed [ELEM_WIDTH-1:0] rd0;
  logic signed [ELEM_WIDTH-1:0] rd1;
  logic [63:0]                  minor_mem [MS];
  logic [63:0]                  mn_rd;
  logic                         mn_zero;

  // divider
  logic [ELEM_WIDTH-1:0] dv_quo;
  logic [7:0]            dv_rem;
  logic [CW-1:0]         dv_cnt;
  logic                  dv_neg;

  // combinational helpers
  logic [IW-1:0]                ia_i;
  logic [IW-1:0]                ib_i;
  logic [NW-1:0]                n_eff;
  logic [NW-1:0]                rowsz;
  logic [IW-1:0]                row_i;
  logic [MAX_ORDER-1:0]         full;
  logic [MAX_ORDER-1:0]         maddr;
  logic [AW-1:0]                addr_p;
  logic [AW-1:0]                addr_q;
  logic [AW-1:0]                addr_tu;
  logic [AW-1:0]                addr_ut;
  logic [AW-1:0]                ra0;
  logic [AW-1:0]                ra1;
  logic [AW-1:0]                wa;
  logic signed [ELEM_WIDTH-1:0] wd;
  logic                         we;
  logic signed [ELEM_WIDTH+7:0] kq;
  logic signed [ELEM_WIDTH-1:0] sum;
  logic [ELEM_WIDTH-1:0]        ma;
  logic [7:0]                   mk;
  logic [8:0]                   shifted;
  logic                         ge;
  logic [ELEM_WIDTH-1:0]        quot;
  logic [63:0]                  minor_v;
  logic signed [31:0]           mul_a;
  logic [31:0]                  mul_b;
  logic signed [64:0]           mul_p;
  logic [63:0]                  term;
  logic                         in_sc;
  logic                         bad;

  function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r,
                                              input logic [IW-1:0] col);
    cell_addr = AW'(r) * AW'(MAX_ORDER) + AW'(col);
  endfunction

  // indices and order
  assign ia_i  = IW'(ia);
  assign ib_i  = IW'(ib);
  assign n_eff = (order == 4'd0) ? NW'(1) :
                 (32'(order) > MAX_ORDER) ? NW'(MAX_ORDER) : NW'(order);

  // line and transpose addresses
  assign addr_p  = rows ? cell_addr(ia_i, t) : cell_addr(t, ia_i);
  assign addr_q  = rows ? cell_addr(ib_i, t) : cell_addr(t, ib_i);
  assign addr_tu = cell_addr(t, u);
  assign addr_ut = cell_addr(u, t);

  // minor row index and full mask
  always_comb begin
    rowsz = '0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      rowsz = rowsz + NW'(mask[i]);
    end
  end
  assign row_i = IW'(rowsz - NW'(1));

  always_comb begin
    for (int i = 0; i < MAX_ORDER; i++) begin
      full[i] = (i < 32'(n));
    end
  end

  assign maddr = mask ^ (MAX_ORDER'(1) << c);

  // read addresses
  always_comb begin
    if (cmd.op == imde_pkg::S_EV_SCAN) begin
      ra0 = cell_addr(row_i, c);
      ra1 = addr_q;
    end else if (func == imde_pkg::FUNC_TRANSPOSE) begin
      ra0 = addr_tu;
      ra1 = addr_ut;
    end else begin
      ra0 = addr_p;
      ra1 = addr_q;
    end
  end

  // add-multiple and divide arithmetic
  assign kq      = k * rd1;
  assign sum     = rd0 + kq[ELEM_WIDTH-1:0];
  assign ma      = rd0[ELEM_WIDTH-1] ? ELEM_WIDTH'(-rd0) : ELEM_WIDTH'(rd0);
  assign mk      = k[7] ? 8'(-k) : 8'(k);
  assign shifted = {dv_rem, dv_quo[ELEM_WIDTH-1]};
  assign ge      = (shifted >= {1'b0, mk});
  assign quot    = dv_neg ? ELEM_WIDTH'(-dv_quo) : dv_quo;

  // write port
  always_comb begin
    we = 1'b1;
    wa = addr_p;
    wd = rd1;
    case (cmd.op)
      imde_pkg::S_WRITE: begin
        wa = cell_addr(ia_i, ib_i);
        wd = ev[ELEM_WIDTH-1:0];
      end
      imde_pkg::S_TR_W0: begin
        wa = addr_tu;
        wd = rd1;
      end
      imde_pkg::S_TR_W1: begin
        wa = addr_ut;
        wd = rd0;
      end
      imde_pkg::S_SW_W0: begin
        wa = addr_p;
        wd = rd1;
      end
      imde_pkg::S_SW_W1: begin
        wa = addr_q;
        wd = rd0;
      end
      imde_pkg::S_AD_WR: begin
        wa = addr_p;
        wd = sum;
      end
      imde_pkg::S_FO_WR: begin
        wa = addr_p;
        wd = quot;
      end
      default: we = 1'b0;
    endcase
  end

  // matrix store
  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    if (cmd.op == imde_pkg::S_RD || cmd.op == imde_pkg::S_EV_SCAN) begin
      rd0 <= mem[ra0];
      rd1 <= mem[ra1];
    end
  end

  // minor store, the empty minor reads as one
  always_ff @(posedge clk) begin
    if (cmd.op == imde_pkg::S_EV_STORE) minor_mem[mask] <= acc;
    if (cmd.op == imde_pkg::S_EV_SCAN) begin
      mn_rd   <= minor_mem[maddr];
      mn_zero <= (maddr == '0);
    end
  end
  assign minor_v = mn_zero ? 64'd1 : mn_rd;

  // shared multiplier, 64-bit products in two 32-bit halves
  assign in_sc = (cmd.op == imde_pkg::S_SC0) || (cmd.op == imde_pkg::S_SC1);
  assign mul_a = in_sc ? coefficient : 32'(rd0);
  always_comb begin
    case (cmd.op)
      imde_pkg::S_EV_M0: mul_b = minor_v[31:0];
      imde_pkg::S_EV_M1: mul_b = minor_v[63:32];
      imde_pkg::S_SC0:   mul_b = det[31:0];
      imde_pkg::S_SC1:   mul_b = det[63:32];
      default:           mul_b = '0;
    endcase
  end
  assign mul_p = mul_a * $signed({1'b0, mul_b});
  assign term  = p0 + {p1, 32'd0};

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      order <= 4'd3;
    end else if (cfg_we) begin
      order <= cfg_data;
    end
  end

  // coefficient
  always_ff @(posedge clk) begin
    if (rst) begin
      coefficient <= 32'sd1;
    end else if (cmd.op == imde_pkg::S_FIN && !bad) begin
      if (func == imde_pkg::FUNC_SWAP && ia != ib) begin
        coefficient <= -coefficient;
      end else if (func == imde_pkg::FUNC_FACTOR) begin
        coefficient <= 32'(coefficient * k);
      end
    end
  end

  // sequenced datapath registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func   <= item.func;
      ia     <= item.index_a;
      ib     <= item.index_b;
      rows   <= item.on_rows;
      k      <= item.factor;
      ev     <= item.element_value;
      n      <= n_eff;
      t      <= '0;
      u      <= IW'(1);
      det    <= '0;
      scaled <= '0;
    end
    case (cmd.op)
      imde_pkg::S_TR_W1: begin
        if (32'(u) == 32'(n) - 1) begin
          t <= t + IW'(1);
          u <= t + IW'(2);
        end else begin
          u <= u + IW'(1);
        end
      end
      imde_pkg::S_SW_W1,
      imde_pkg::S_AD_WR,
      imde_pkg::S_FO_WR: t <= t + IW'(1);
      imde_pkg::S_DV_LOAD: begin
        dv_quo <= ma;
        dv_rem <= '0;
        dv_cnt <= '0;
        dv_neg <= rd0[ELEM_WIDTH-1] ^ k[7];
      end
      imde_pkg::S_DV_STEP: begin
        dv_rem <= ge ? 8'(shifted - {1'b0, mk}) : shifted[7:0];
        dv_quo <= {dv_quo[ELEM_WIDTH-2:0], ge};
        dv_cnt <= dv_cnt + CW'(1);
      end
      imde_pkg::S_EV_INIT: begin
        mask  <= MAX_ORDER'(1);
        c     <= IW'(32'(n) - 1);
        acc   <= '0;
        above <= 1'b0;
      end
      imde_pkg::S_EV_SCAN: begin
        if (!mask[c] && c != '0) c <= c - IW'(1);
      end
      imde_pkg::S_EV_M0: p0 <= mul_p[63:0];
      imde_pkg::S_EV_M1: p1 <= mul_p[31:0];
      imde_pkg::S_EV_ACC: begin
        acc   <= above ? acc - term : acc + term;
        above <= ~above;
        if (c != '0) c <= c - IW'(1);
      end
      imde_pkg::S_EV_STORE: begin
        if (mask == full) begin
          det <= acc;
        end else begin
          mask  <= mask + MAX_ORDER'(1);
          c     <= IW'(32'(n) - 1);
          acc   <= '0;
          above <= 1'b0;
        end
      end
      imde_pkg::S_SC0: p0 <= mul_p[63:0];
      imde_pkg::S_SC1: p1 <= mul_p[31:0];
      imde_pkg::S_SC2: scaled <= term;
      default: ;
    endcase
  end

  // status toward the controller
  always_comb begin
    case (func)
      imde_pkg::FUNC_WRITE,
      imde_pkg::FUNC_SWAP,
      imde_pkg::FUNC_ADD:       bad = (32'(ia) >= 32'(n)) || (32'(ib) >= 32'(n));
      imde_pkg::FUNC_FACTOR:    bad = (32'(ia) >= 32'(n)) || (k == 8'sd0);
      imde_pkg::FUNC_TRANSPOSE,
      imde_pkg::FUNC_EVAL:      bad = 1'b0;
      default:                  bad = 1'b1;
    endcase
  end
  assign sts.bad       = bad;
  assign sts.func      = func;
  assign sts.skip      = (func == imde_pkg::FUNC_TRANSPOSE) ? (n < NW'(2)) : (ia == ib);
  assign sts.t_last    = (32'(t) == 32'(n) - 1);
  assign sts.pair_last = (32'(t) == 32'(n) - 2) && (32'(u) == 32'(n) - 1);
  assign sts.bit_set   = mask[c];
  assign sts.c_zero    = (c == '0);
  assign sts.mask_full = (mask == full);
  assign sts.div_last  = (dv_cnt == CW'(ELEM_WIDTH - 1));

  // result fields
  assign result.det_value    = det;
  assign result.scaled_value = scaled;
  assign result.coeff_out    = coefficient;
  assign result.bad_op       = bad;

endmodule

`default_nettype wire

// ----- src/integer_matrix_determinant_engine.sv -----
// top level of the integer matrix determinant engine
//
// A transaction is taken at a clock edge with start high and busy low; busy
// stays high until its one result has been shown. The result sits on the
// result port for one cycle with done high and is taken at the end of that
// cycle; nothing holds it off. cfg_we with cfg_data writes the matrix order;
// the user writes it only while busy is low; the block does not enforce it.
// Evaluation walks every column subset once, each term of its columns
// through one shared 32x33 multiplier in two halves; factor out runs a
// one-bit-a-cycle divider per element. One transaction is in flight at a
// time. Reset sets the order to three and the coefficient to one; the
// matrix holds nothing until written.
`default_nettype none

module integer_matrix_determinant_engine #(
  parameter int MAX_ORDER  = 8,
  parameter int ELEM_WIDTH = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire imde_pkg::imde_item_t item,
  input  wire logic                 cfg_we,
  input  wire logic [3:0]           cfg_data,
  output logic                      done,
  output imde_pkg::imde_result_t    result
);

  imde_pkg::imde_cmd_t cmd;
  imde_pkg::imde_sts_t sts;

  // sequencer
  imde_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // datapath
  imde_dp #(
    .MAX_ORDER  (MAX_ORDER),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .item     (item),
    .cmd      (cmd),
    .sts      (sts),
    .result   (result)
  );

endmodule

`default_nettype wire

// ----- src/imde_chk.sv -----
// port checker of the determinant engine and its bind
`default_nettype none

module imde_chk (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // a result belongs to a transaction in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without a transaction in flight");

  // the engine is free again right after its result
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("busy after result");

  // a taken transaction occupies the engine
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("transaction taken but engine not busy");

  // no result in the cycle after a transaction is taken
  a_take_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> !done)
    else $error("result too early");

endmodule

bind integer_matrix_determinant_engine imde_chk u_imde_chk (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
